// ===== design/fcpc_pkg.sv =====
package fcpc_pkg;

  localparam int DEF_TABLE_ROWS = 8;
  localparam int DEF_PING_COUNT = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_PING  = 2'd1;
  localparam logic [1:0] FUNC_STAGE = 2'd2;
  localparam logic [1:0] FUNC_RESET = 2'd3;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_SWITCH = 2'd1;
  localparam logic [1:0] ACT_LIMIT  = 2'd2;

  localparam logic [15:0] LIMIT_NONE   = 16'd0;
  localparam logic [15:0] LIMIT_SWITCH = 16'd1;

  typedef struct packed {
    logic [3:0]  source;
    logic [15:0] ping_min;
    logic [15:0] ping_max;
    logic [15:0] stage_min;
    logic [15:0] stage_max;
    logic [15:0] limit;
  } row_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] cur;
    logic [3:0]  src;
    logic [2:0]  idx;
    row_t        row;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] limit;
    logic [2:0]  level;
    logic        stage;
    logic [15:0] measured;
  } res_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage

// ===== design/current_fod_ping_classifier.sv =====
// channel   | handshake                     | payload
// item      | item_valid / item_stall       | func, tx_current, power_source, entry_*
// result    | result_valid / result_stall   | action, current_limit, level_index,
//           |                               | from_stage, measured_current
// config    | table_levels_we               | table_levels_wdata
//
// the front takes a request each cycle while the two-entry queue has room
// the back handles a write, a reset or a sample that starts no scan while idle; a stage
// scan starts at once, a closing ping passes ST_MUL and ST_AVG first (no scan with no
// rows in use); one row read a cycle; a match ends the scan and holds on result_stall
// rst is synchronous; it clears the sample window, the stored limit and table_levels
// table rows hold no reset value and must be written before they are used
module current_fod_ping_classifier #(
  parameter int TABLE_ROWS = fcpc_pkg::DEF_TABLE_ROWS,
  parameter int PING_COUNT = fcpc_pkg::DEF_PING_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        table_levels_we,
  input  logic [3:0]  table_levels_wdata,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  func,
  input  logic [15:0] tx_current,
  input  logic [3:0]  power_source,
  input  logic [2:0]  entry_index,
  input  logic [3:0]  entry_source,
  input  logic [15:0] entry_ping_min,
  input  logic [15:0] entry_ping_max,
  input  logic [15:0] entry_stage_min,
  input  logic [15:0] entry_stage_max,
  input  logic [15:0] entry_limit,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  action,
  output logic [15:0] current_limit,
  output logic [2:0]  level_index,
  output logic        from_stage,
  output logic [15:0] measured_current
);
  import fcpc_pkg::*;

  logic [3:0] table_levels;
  q_stat_t    q_stat;
  logic       q_push;
  logic       q_pop;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  res_t       result;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_levels <= '0;
    end else if (table_levels_we) begin
      table_levels <= table_levels_wdata;
    end
  end

  fcpc_front #(
    .TABLE_ROWS(TABLE_ROWS)
  ) u_front (
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .func            (func),
    .tx_current      (tx_current),
    .power_source    (power_source),
    .entry_index     (entry_index),
    .entry_source    (entry_source),
    .entry_ping_min  (entry_ping_min),
    .entry_ping_max  (entry_ping_max),
    .entry_stage_min (entry_stage_min),
    .entry_stage_max (entry_stage_max),
    .entry_limit     (entry_limit),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  fcpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  fcpc_back #(
    .TABLE_ROWS(TABLE_ROWS),
    .PING_COUNT(PING_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .table_levels (table_levels),
    .q_nonempty   (q_stat.nonempty),
    .q_cmd        (head_cmd),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign action           = result.action;
  assign current_limit    = result.limit;
  assign level_index      = result.level;
  assign from_stage       = result.stage;
  assign measured_current = result.measured;

`ifndef SYNTHESIS
  a_action_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((action == ACT_NONE) == (current_limit == LIMIT_NONE)) &&
                     ((action == ACT_SWITCH) == (current_limit == LIMIT_SWITCH)))
    else $error("action does not agree with current_limit");

  a_level_in_use: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, level_index} < table_levels))
    else $error("matched row lies beyond table_levels");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.nonempty && !result_valid)
    else $error("back took an item from an empty queue or while a result waits");
`endif

endmodule

// ===== design/fcpc_queue.sv =====
module fcpc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fcpc_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output fcpc_pkg::cmd_t    head_cmd,
  output fcpc_pkg::q_stat_t stat
);
  import fcpc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign stat.full     = (32'(count) == QUEUE_DEPTH);
  assign stat.nonempty = (count != '0);
  assign do_push       = push && !stat.full;
  assign do_pop        = pop && stat.nonempty;
  assign head_cmd      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/fcpc_front.sv =====
module fcpc_front #(
  parameter int TABLE_ROWS = fcpc_pkg::DEF_TABLE_ROWS
) (
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        func,
  input  logic [15:0]       tx_current,
  input  logic [3:0]        power_source,
  input  logic [2:0]        entry_index,
  input  logic [3:0]        entry_source,
  input  logic [15:0]       entry_ping_min,
  input  logic [15:0]       entry_ping_max,
  input  logic [15:0]       entry_stage_min,
  input  logic [15:0]       entry_stage_max,
  input  logic [15:0]       entry_limit,
  input  fcpc_pkg::q_stat_t q_stat,
  output logic              q_push,
  output fcpc_pkg::cmd_t    q_cmd
);
  import fcpc_pkg::*;

  logic keep;

  // writes beyond TABLE_ROWS and pings with zero current are dropped here
  always_comb begin
    unique case (func)
      FUNC_WRITE: keep = (32'(entry_index) < TABLE_ROWS);
      FUNC_PING:  keep = (tx_current != 16'd0);
      FUNC_STAGE: keep = 1'b1;
      FUNC_RESET: keep = 1'b1;
      default:    keep = 1'b1;
    endcase
  end

  assign item_stall = q_stat.full;
  assign q_push     = item_valid && !q_stat.full && keep;

  assign q_cmd.func          = func;
  assign q_cmd.cur           = tx_current;
  assign q_cmd.src           = power_source;
  assign q_cmd.idx           = entry_index;
  assign q_cmd.row.source    = entry_source;
  assign q_cmd.row.ping_min  = entry_ping_min;
  assign q_cmd.row.ping_max  = entry_ping_max;
  assign q_cmd.row.stage_min = entry_stage_min;
  assign q_cmd.row.stage_max = entry_stage_max;
  assign q_cmd.row.limit     = entry_limit;

endmodule

// ===== design/fcpc_back.sv =====
module fcpc_back #(
  parameter int TABLE_ROWS = fcpc_pkg::DEF_TABLE_ROWS,
  parameter int PING_COUNT = fcpc_pkg::DEF_PING_COUNT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [3:0]     table_levels,
  input  logic           q_nonempty,
  input  fcpc_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           result_valid,
  input  logic           result_stall,
  output fcpc_pkg::res_t result
);
  import fcpc_pkg::*;

  localparam int RW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int IW = $clog2(TABLE_ROWS + 1);
  localparam int CW = $clog2(PING_COUNT + 1);
  localparam int SW = 16 + $clog2(PING_COUNT);
  // average by reciprocal multiply, exact for every sum below 2**SW
  localparam int K = SW + $clog2(PING_COUNT) + 1;
  localparam logic [K:0] RECIP = (K + 1)'(((64'd1 << K) + PING_COUNT - 1) / PING_COUNT);
  localparam int PW = SW + K + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_AVG  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  row_t          rows_mem [TABLE_ROWS];
  row_t          rd_data;
  logic [RW-1:0] rd_addr;
  logic          mem_we;

  logic [2:0]    state;
  logic [CW-1:0] sample_count;
  logic [SW-1:0] sample_sum;
  logic [15:0]   stored_limit;
  logic [PW-1:0] product;
  logic [15:0]   value;
  logic          stage_sel;
  logic [3:0]    src_sel;
  logic [IW-1:0] issue_idx;
  logic          chk_valid;
  logic [RW-1:0] chk_idx;

  logic [IW-1:0] rows;
  logic [15:0]   lo;
  logic [15:0]   hi;
  logic          hit;
  logic          last;
  logic [1:0]    act;

  always_comb begin
    if (32'(table_levels) > TABLE_ROWS) begin
      rows = IW'(TABLE_ROWS);
    end else begin
      rows = IW'(table_levels);
    end
  end

  assign q_pop        = (state == ST_IDLE) && q_nonempty;
  assign mem_we       = q_pop && (q_cmd.func == FUNC_WRITE);
  assign rd_addr      = RW'(issue_idx);
  assign result_valid = (state == ST_OUT);

  assign lo   = stage_sel ? rd_data.stage_min : rd_data.ping_min;
  assign hi   = stage_sel ? rd_data.stage_max : rd_data.ping_max;
  assign hit  = chk_valid && (rd_data.source == src_sel) && (value >= lo) && (value < hi);
  assign last = chk_valid && (32'(chk_idx) + 1 == 32'(rows));

  always_comb begin
    if (rd_data.limit == LIMIT_NONE) begin
      act = ACT_NONE;
    end else if (rd_data.limit == LIMIT_SWITCH) begin
      act = ACT_SWITCH;
    end else begin
      act = ACT_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rows_mem[RW'(q_cmd.idx)] <= q_cmd.row;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= rows_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      product <= PW'(sample_sum) * PW'(RECIP);
    end
    if (hit && state == ST_SCAN) begin
      result.action   <= act;
      result.limit    <= rd_data.limit;
      result.level    <= 3'(chk_idx);
      result.stage    <= stage_sel;
      result.measured <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_count <= '0;
      sample_sum   <= '0;
      stored_limit <= '0;
      stage_sel    <= 1'b0;
      src_sel      <= '0;
      value        <= '0;
      issue_idx    <= '0;
      chk_valid    <= 1'b0;
      chk_idx      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          issue_idx <= '0;
          chk_valid <= 1'b0;
          if (q_pop) begin
            src_sel <= q_cmd.src;
            case (q_cmd.func)
              FUNC_RESET: begin
                sample_count <= '0;
                sample_sum   <= '0;
                stored_limit <= '0;
              end
              FUNC_PING: begin
                if (32'(sample_count) < PING_COUNT) begin
                  sample_sum   <= sample_sum + SW'(q_cmd.cur);
                  sample_count <= sample_count + 1'b1;
                  stage_sel    <= 1'b0;
                  if (32'(sample_count) + 1 == PING_COUNT) begin
                    state <= ST_MUL;
                  end
                end
              end
              FUNC_STAGE: begin
                if (stored_limit == 16'd0 && rows != '0) begin
                  stage_sel <= 1'b1;
                  value     <= q_cmd.cur;
                  state     <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          state <= ST_AVG;
        end
        ST_AVG: begin
          value <= product[K +: 16];
          state <= (rows != '0) ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          // one row issued and one row checked each cycle
          if (32'(issue_idx) < 32'(rows)) begin
            chk_valid <= 1'b1;
            chk_idx   <= RW'(issue_idx);
            issue_idx <= issue_idx + 1'b1;
          end else begin
            chk_valid <= 1'b0;
          end
          if (hit) begin
            stored_limit <= rd_data.limit;
            state        <= ST_OUT;
          end else if (last) begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (!result_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcpc_pkg::*;

  localparam int ROWS = DEF_TABLE_ROWS;
  localparam int PINGS = DEF_PING_COUNT;
  // upper bound on the back-end time of the queued requests that bring no result
  localparam int SETTLE_CYCLES = 48;
  localparam int PHASE_ITEMS = 60;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_RESULT} chk_e;

  typedef struct {
    logic [3:0] levels;
    cmd_t       c;
    chk_e       chk;
    res_t       want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        table_levels_we;
  logic [3:0]  table_levels_wdata;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  func;
  logic [15:0] tx_current;
  logic [3:0]  power_source;
  logic [2:0]  entry_index;
  logic [3:0]  entry_source;
  logic [15:0] entry_ping_min;
  logic [15:0] entry_ping_max;
  logic [15:0] entry_stage_min;
  logic [15:0] entry_stage_max;
  logic [15:0] entry_limit;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  action;
  logic [15:0] current_limit;
  logic [2:0]  level_index;
  logic        from_stage;
  logic [15:0] measured_current;

  // shadow of the classifier state
  logic [3:0]  cfg_levels;
  int          win_count;
  logic [17:0] win_sum;
  logic [15:0] held_limit;
  row_t        tab [ROWS];

  res_t pending_q[$];
  int   errors;
  int   live_items;
  int   gap_rate;
  bit   quiet;
  int   stall_left = 0;

  current_fod_ping_classifier uut (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit classify(input cmd_t c, output res_t r, output bit used);
    int rows;
    int hit_row;
    logic [15:0] val;
    logic [15:0] lo;
    logic [15:0] hi;
    bit stage;
    r = '0;
    used = 1'b1;
    hit_row = -1;
    stage = 1'b0;
    val = c.cur;
    case (c.func)
      FUNC_WRITE: begin
        tab[c.idx] = c.row;
        return 1'b0;
      end
      FUNC_RESET: begin
        win_count = 0;
        win_sum = '0;
        held_limit = '0;
        return 1'b0;
      end
      FUNC_PING: begin
        if (win_count >= PINGS || c.cur == 16'd0) begin
          used = 1'b0;
          return 1'b0;
        end
        win_sum += c.cur;
        win_count++;
        if (win_count < PINGS) return 1'b0;
        val = 16'(win_sum / PINGS);
      end
      default: begin
        // stage samples only count while no nonzero limit is held
        if (held_limit != 16'd0) begin
          used = 1'b0;
          return 1'b0;
        end
        stage = 1'b1;
      end
    endcase
    rows = (cfg_levels > ROWS) ? ROWS : cfg_levels;
    for (int i = 0; i < rows; i++) begin
      lo = stage ? tab[i].stage_min : tab[i].ping_min;
      hi = stage ? tab[i].stage_max : tab[i].ping_max;
      if (hit_row < 0 && tab[i].source == c.src && val >= lo && val < hi) hit_row = i;
    end
    if (hit_row < 0) return 1'b0;
    held_limit = tab[hit_row].limit;
    if (held_limit == LIMIT_NONE) r.action = ACT_NONE;
    else if (held_limit == LIMIT_SWITCH) r.action = ACT_SWITCH;
    else r.action = ACT_LIMIT;
    r.limit = held_limit;
    r.level = 3'(hit_row);
    r.stage = stage;
    r.measured = val;
    return 1'b1;
  endfunction

  // exclusive upper bound for a range starting at lo
  function automatic logic [15:0] rand_top(input logic [15:0] lo);
    case ($urandom_range(0, 19))
      0, 1, 2: return 16'($urandom_range(0, lo));
      3, 4, 5: return 16'($urandom_range(lo, 16'hFFFF));
      default: return (lo > 16'hFFFF - 16'd4000) ? 16'hFFFF : lo + 16'($urandom_range(1, 4000));
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t r;
    r.source = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    r.ping_min = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    r.ping_max = rand_top(r.ping_min);
    r.stage_min = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    r.stage_max = rand_top(r.stage_min);
    case ($urandom_range(0, 5))
      0: r.limit = LIMIT_NONE;
      1: r.limit = LIMIT_SWITCH;
      2: r.limit = 16'hFFFF;
      3: r.limit = 16'd2;
      default: r.limit = 16'($urandom);
    endcase
    return r;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.func = 2'($urandom_range(0, 3));
    c.cur = 16'($urandom);
    c.src = 4'($urandom_range(0, 15));
    c.idx = 3'($urandom_range(0, 7));
    c.row = rand_row();
    return c;
  endfunction

  function automatic logic [15:0] aim(input logic [15:0] lo, input logic [15:0] hi);
    return (lo < hi) ? 16'($urandom_range(lo, hi - 16'd1)) : 16'($urandom);
  endfunction

  function automatic step_t make_step(input logic [3:0] lv, input logic [1:0] fn,
                                      input logic [15:0] cur, input logic [3:0] src,
                                      input chk_e chk, input res_t want);
    step_t s;
    s.levels = lv;
    s.c = '0;
    s.c.func = fn;
    s.c.cur = cur;
    s.c.src = src;
    s.chk = chk;
    s.want = want;
    return s;
  endfunction

  task automatic push_item(input cmd_t c, input chk_e chk, input res_t want, output bit used);
    res_t r;
    bit hit;
    int n;
    @(negedge clk);
    item_valid <= 1'b1;
    func <= c.func;
    tx_current <= c.cur;
    power_source <= c.src;
    entry_index <= c.idx;
    entry_source <= c.row.source;
    entry_ping_min <= c.row.ping_min;
    entry_ping_max <= c.row.ping_max;
    entry_stage_min <= c.row.stage_min;
    entry_stage_max <= c.row.stage_max;
    entry_limit <= c.row.limit;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    hit = classify(c, r, used);
    if (chk == CHK_RESULT) pending_q.push_back(want);
    else if (chk == CHK_PREDICT && hit) pending_q.push_back(r);
    if (!quiet && $urandom_range(0, 9) < gap_rate) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        @(negedge clk);
        item_valid <= 1'b0;
      end
    end
  endtask

  task automatic send(input cmd_t c);
    bit used;
    push_item(c, CHK_PREDICT, '0, used);
    if (used) live_items++;
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_levels(input logic [3:0] v);
    settle();
    @(negedge clk);
    table_levels_we <= 1'b1;
    table_levels_wdata <= v;
    @(negedge clk);
    table_levels_we <= 1'b0;
    cfg_levels = v;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!rst && !quiet && $urandom_range(0, 9) < gap_rate) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && result_valid && !result_stall) begin
      got = res_t'{action, current_limit, level_index, from_stage, measured_current};
      if (pending_q.size() == 0) begin
        $display("%0t: result with none expected, actual act=%0d lim=%0d row=%0d stage=%0d cur=%0d",
                 $time, got.action, got.limit, got.level, got.stage, got.measured);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          $display("%0t: expected act=%0d lim=%0d row=%0d stage=%0d cur=%0d", $time,
                   want.action, want.limit, want.level, want.stage, want.measured);
          $display("%0t:   actual act=%0d lim=%0d row=%0d stage=%0d cur=%0d", $time,
                   got.action, got.limit, got.level, got.stage, got.measured);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    step_t plan[$];
    step_t s;
    row_t seed_rows [ROWS];
    logic [3:0] phase_levels [6];
    cmd_t c;
    bit used;
    int phase_end;
    int t;
    logic [3:0] src;
    logic [15:0] a;
    logic [15:0] k;
    logic [15:0] spread;
    logic [15:0] samples [4];

    rst = 1'b1;
    table_levels_we = 1'b0;
    table_levels_wdata = '0;
    item_valid = 1'b0;
    func = '0;
    tx_current = '0;
    power_source = '0;
    entry_index = '0;
    entry_source = '0;
    entry_ping_min = '0;
    entry_ping_max = '0;
    entry_stage_min = '0;
    entry_stage_max = '0;
    entry_limit = '0;
    cfg_levels = '0;
    win_count = 0;
    win_sum = '0;
    held_limit = '0;
    errors = 0;
    live_items = 0;
    gap_rate = 3;
    quiet = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    seed_rows = '{
      row_t'{4'd0, 16'd0, 16'd100, 16'd0, 16'd100, LIMIT_NONE},
      row_t'{4'd0, 16'd100, 16'd1000, 16'd100, 16'd1000, LIMIT_SWITCH},
      row_t'{4'd0, 16'd1000, 16'hFFFF, 16'd1000, 16'hFFFF, 16'hFFFF},
      row_t'{4'd5, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd500},
      row_t'{4'd5, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd600},
      row_t'{4'd10, 16'd200, 16'd300, 16'd200, 16'd300, 16'd700},
      row_t'{4'd10, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, LIMIT_SWITCH},
      row_t'{4'd15, 16'hFFFE, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'd2}
    };
    // every row is written first so no match ever reads an empty row
    foreach (seed_rows[i]) begin
      s = make_step(4'd0, FUNC_WRITE, 16'd0, 4'd0, CHK_NONE, '0);
      s.c.idx = 3'(i);
      s.c.row = seed_rows[i];
      plan.push_back(s);
    end
    // matching off: a full window gives nothing
    repeat (4) plan.push_back(make_step(4'd0, FUNC_PING, 16'd50, 4'd0, CHK_NONE, '0));
    plan.push_back(make_step(4'd0, FUNC_RESET, 16'd0, 4'd0, CHK_NONE, '0));
    // levels above the table size scan all rows, last row included
    plan.push_back(make_step(4'd15, FUNC_PING, 16'd0, 4'd15, CHK_NONE, '0));
    repeat (3) plan.push_back(make_step(4'd15, FUNC_PING, 16'hFFFF, 4'd15, CHK_NONE, '0));
    plan.push_back(make_step(4'd15, FUNC_PING, 16'hFFFC, 4'd15, CHK_RESULT,
                             res_t'{ACT_LIMIT, 16'd2, 3'd7, 1'b0, 16'hFFFE}));
    plan.push_back(make_step(4'd15, FUNC_PING, 16'hFFFF, 4'd15, CHK_NONE, '0));
    plan.push_back(make_step(4'd15, FUNC_STAGE, 16'hFFFE, 4'd15, CHK_NONE, '0));
    plan.push_back(make_step(4'd15, FUNC_RESET, 16'd0, 4'd0, CHK_NONE, '0));
    plan.push_back(make_step(4'd15, FUNC_STAGE, 16'd50, 4'd0, CHK_RESULT,
                             res_t'{ACT_NONE, 16'd0, 3'd0, 1'b1, 16'd50}));
    plan.push_back(make_step(4'd15, FUNC_STAGE, 16'd150, 4'd0, CHK_RESULT,
                             res_t'{ACT_SWITCH, 16'd1, 3'd1, 1'b1, 16'd150}));
    plan.push_back(make_step(4'd15, FUNC_RESET, 16'd0, 4'd0, CHK_NONE, '0));
    plan.push_back(make_step(4'd15, FUNC_STAGE, 16'd2000, 4'd0, CHK_RESULT,
                             res_t'{ACT_LIMIT, 16'hFFFF, 3'd2, 1'b1, 16'd2000}));
    plan.push_back(make_step(4'd1, FUNC_RESET, 16'd0, 4'd0, CHK_NONE, '0));
    plan.push_back(make_step(4'd1, FUNC_STAGE, 16'd150, 4'd0, CHK_NONE, '0));
    plan.push_back(make_step(4'd1, FUNC_STAGE, 16'd0, 4'd0, CHK_RESULT,
                             res_t'{ACT_NONE, 16'd0, 3'd0, 1'b1, 16'd0}));

    foreach (plan[i]) begin
      if (i == 0 || plan[i].levels != plan[i - 1].levels) write_levels(plan[i].levels);
      push_item(plan[i].c, plan[i].chk, plan[i].want, used);
    end

    phase_levels = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd0, 4'd8};
    phase_levels[4] = 4'($urandom_range(1, 14));
    for (int p = 0; p < 6; p++) begin
      write_levels(phase_levels[p]);
      gap_rate = $urandom_range(0, 4);
      quiet = (p == 5);
      phase_end = live_items + PHASE_ITEMS;
      repeat (2) begin
        c = rand_cmd();
        c.func = FUNC_WRITE;
        send(c);
      end
      while (live_items < phase_end) begin
        t = $urandom_range(0, ROWS - 1);
        src = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : tab[t].source;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // window of four samples around a chosen row's ping range
            a = aim(tab[t].ping_min, tab[t].ping_max);
            if (a == 16'd0) a = 16'd1;
            spread = a - 16'd1;
            if (16'hFFFF - a < spread) spread = 16'hFFFF - a;
            if (spread > 16'd300) spread = 16'd300;
            k = 16'($urandom_range(0, spread));
            samples[0] = a + k;
            samples[1] = a - k;
            samples[2] = a;
            samples[3] = (a > 16'hFFFC) ? a : a + 16'($urandom_range(0, 3));
            if ($urandom_range(0, 4) != 0) begin
              c = rand_cmd();
              c.func = FUNC_RESET;
              send(c);
            end
            for (int j = 0; j < 4; j++) begin
              if ($urandom_range(0, 9) == 0) send(rand_cmd());
              c = rand_cmd();
              c.func = FUNC_PING;
              c.cur = samples[j];
              c.src = src;
              send(c);
            end
            if ($urandom_range(0, 9) == 0) begin
              c = rand_cmd();
              c.func = FUNC_PING;
              send(c);
            end
          end
          5, 6, 7: begin
            if ($urandom_range(0, 1) == 1) begin
              c = rand_cmd();
              c.func = FUNC_RESET;
              send(c);
            end
            c = rand_cmd();
            c.func = FUNC_STAGE;
            c.src = src;
            c.cur = aim(tab[t].stage_min, tab[t].stage_max);
            send(c);
          end
          8: begin
            c = rand_cmd();
            c.func = FUNC_WRITE;
            send(c);
          end
          default: send(rand_cmd());
        endcase
      end
    end

    settle();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
